[hw/rtl/mme_pkg.sv]
// Shared types and constants for the metatile map expander.
package mme_pkg;

   // Map store depth; a power of two so the cell address wraps by truncation.
   localparam int MAP_CELLS = 256;
   localparam int MAP_AW    = $clog2(MAP_CELLS);
   // Metatile table depth; a power of two, at most 256.
   localparam int METATILES = 256;
   localparam int TILE_AW   = $clog2(METATILES);

   localparam int BYTE_W    = 8;
   localparam int PROD_W    = 2 * BYTE_W;
   localparam int ENTRY_W   = 8 * BYTE_W;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   typedef enum logic [1:0] {
      MODE_MAP_WR  = 2'd0,
      MODE_TILE_WR = 2'd1,
      MODE_DRAW    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1,
      CSR_COL_OFFSET = 2'd2,
      CSR_ROW_OFFSET = 2'd3
   } csr_idx_type;

   typedef enum logic [11:0] {
      S_IDLE    = 12'b0000_0000_0001,
      S_MAP_MUL = 12'b0000_0000_0010,
      S_MAP_WR  = 12'b0000_0000_0100,
      S_TBL_WR  = 12'b0000_0000_1000,
      S_CUR_FIX = 12'b0000_0001_0000,
      S_CUR_MUL = 12'b0000_0010_0000,
      S_MAP_RD  = 12'b0000_0100_0000,
      S_TBL_RD  = 12'b0000_1000_0000,
      S_EMIT0   = 12'b0001_0000_0000,
      S_EMIT1   = 12'b0010_0000_0000,
      S_EMIT2   = 12'b0100_0000_0000,
      S_EMIT3   = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic       capture;     // latch request fields
      logic       mul_en;      // register row * map_width
      logic       mul_cursor;  // multiplier takes cursor row, else cell_y
      logic       map_wr;
      logic       tbl_wr;
      logic       cur_fix;     // restart a stale cursor at (0,0)
      logic       map_rd;
      logic       tbl_rd;      // also advances the cursor
      logic       emit;
      logic [1:0] quarter;
   } cmd_type;

   typedef struct packed {
      logic map_empty;
   } status_type;

endpackage

[hw/rtl/mme_ctrl.sv]
// Sequencer for load and draw steps of the metatile map expander.
module mme_ctrl
   import mme_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_mode,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_MAP_WR:  state_in = S_MAP_MUL;
                  MODE_TILE_WR: state_in = S_TBL_WR;
                  MODE_DRAW:    state_in = status.map_empty ? S_IDLE : S_CUR_FIX;
                  default:      state_in = S_IDLE;
               endcase
            end
         end
         S_MAP_MUL: state_in = S_MAP_WR;
         S_MAP_WR:  state_in = S_IDLE;
         S_TBL_WR:  state_in = S_IDLE;
         S_CUR_FIX: state_in = S_CUR_MUL;
         S_CUR_MUL: state_in = S_MAP_RD;
         S_MAP_RD:  state_in = S_TBL_RD;
         S_TBL_RD:  state_in = S_EMIT0;
         S_EMIT0:   state_in = S_EMIT1;
         S_EMIT1:   state_in = S_EMIT2;
         S_EMIT2:   state_in = S_EMIT3;
         S_EMIT3:   state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.capture    = accept;
      cmd.mul_en     = (state_ff == S_MAP_MUL) || (state_ff == S_CUR_MUL);
      cmd.mul_cursor = (state_ff == S_CUR_MUL);
      cmd.map_wr     = (state_ff == S_MAP_WR);
      cmd.tbl_wr     = (state_ff == S_TBL_WR);
      cmd.cur_fix    = (state_ff == S_CUR_FIX);
      cmd.map_rd     = (state_ff == S_MAP_RD);
      cmd.tbl_rd     = (state_ff == S_TBL_RD);
      cmd.emit       = (state_ff == S_EMIT0) || (state_ff == S_EMIT1) ||
                       (state_ff == S_EMIT2) || (state_ff == S_EMIT3);
      cmd.quarter[0] = (state_ff == S_EMIT1) || (state_ff == S_EMIT3);
      cmd.quarter[1] = (state_ff == S_EMIT2) || (state_ff == S_EMIT3);
   end

endmodule

[hw/rtl/mme_datapath.sv]
// Map store, metatile table, raster cursor and result formatting.
module mme_datapath
   import mme_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [BYTE_W-1:0] map_width,
   input  logic [BYTE_W-1:0] map_height,
   input  logic [BYTE_W-1:0] screen_col_offset,
   input  logic [BYTE_W-1:0] screen_row_offset,
   input  logic [BYTE_W-1:0] req_cell_x,
   input  logic [BYTE_W-1:0] req_cell_y,
   input  logic [BYTE_W-1:0] req_tile_index,
   input  logic [BYTE_W-1:0] req_char_top_left,
   input  logic [BYTE_W-1:0] req_char_top_right,
   input  logic [BYTE_W-1:0] req_char_bottom_left,
   input  logic [BYTE_W-1:0] req_char_bottom_right,
   input  logic [BYTE_W-1:0] req_color_top_left,
   input  logic [BYTE_W-1:0] req_color_top_right,
   input  logic [BYTE_W-1:0] req_color_bottom_left,
   input  logic [BYTE_W-1:0] req_color_bottom_right,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_screen_col,
   output logic [BYTE_W-1:0] rsp_screen_row,
   output logic [BYTE_W-1:0] rsp_char_code,
   output logic [BYTE_W-1:0] rsp_color_value,
   output logic              rsp_cell_last,
   output logic              rsp_map_done
);

   logic [BYTE_W-1:0]  map_mem [MAP_CELLS];
   logic [ENTRY_W-1:0] tbl_mem [METATILES];

   logic [BYTE_W-1:0]  cell_x_ff, cell_y_ff, tile_ff;
   logic [ENTRY_W-1:0] entry_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [BYTE_W-1:0]  cur_col_ff, cur_row_ff, cur_col_in, cur_row_in;
   logic [BYTE_W-1:0]  map_q_ff;
   logic [ENTRY_W-1:0] tile_q_ff;
   logic [BYTE_W-1:0]  base_col_ff, base_row_ff;
   logic               done_ff, done_in;

   logic [BYTE_W-1:0]  mul_a;
   logic [PROD_W-1:0]  wr_sum, rd_sum;
   logic [BYTE_W-1:0]  next_col, next_row;
   logic               stale;
   logic [2:0]         char_sel;
   logic [2:0]         color_sel;

   assign status.map_empty = (map_width == '0) || (map_height == '0);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cell_x_ff <= req_cell_x;
         cell_y_ff <= req_cell_y;
         tile_ff   <= req_tile_index;
         entry_ff  <= {req_color_bottom_right, req_color_bottom_left,
                       req_color_top_right, req_color_top_left,
                       req_char_bottom_right, req_char_bottom_left,
                       req_char_top_right, req_char_top_left};
      end
   end

   assign mul_a = cmd.mul_cursor ? cur_row_ff : cell_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= {{(PROD_W-BYTE_W){1'b0}}, mul_a} *
                    {{(PROD_W-BYTE_W){1'b0}}, map_width};
      end
   end

   // Cell addresses wrap at the store depth by truncation.
   assign wr_sum = prod_ff + {{(PROD_W-BYTE_W){1'b0}}, cell_x_ff};
   assign rd_sum = prod_ff + {{(PROD_W-BYTE_W){1'b0}}, cur_col_ff};

   always_ff @(posedge clock) begin
      if (cmd.map_wr) begin
         map_mem[wr_sum[MAP_AW-1:0]] <= tile_ff;
      end
      if (cmd.map_rd) begin
         map_q_ff <= map_mem[rd_sum[MAP_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_wr) begin
         tbl_mem[tile_ff[TILE_AW-1:0]] <= entry_ff;
      end
      if (cmd.tbl_rd) begin
         tile_q_ff <= tbl_mem[map_q_ff[TILE_AW-1:0]];
      end
   end

   // Cursor: col < width and row < height hold after the fix, so +1 fits.
   assign stale    = (cur_col_ff >= map_width) || (cur_row_ff >= map_height);
   assign next_col = cur_col_ff + 8'd1;
   assign next_row = cur_row_ff + 8'd1;

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      done_in    = done_ff;
      if (cmd.cur_fix && stale) begin
         cur_col_in = '0;
         cur_row_in = '0;
      end else if (cmd.tbl_rd) begin
         done_in = 1'b0;
         if (next_col >= map_width) begin
            cur_col_in = '0;
            if (next_row >= map_height) begin
               cur_row_in = '0;
               done_in    = 1'b1;
            end else begin
               cur_row_in = next_row;
            end
         end else begin
            cur_col_in = next_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_rd) begin
         base_col_ff <= {cur_col_ff[BYTE_W-2:0], 1'b0} + screen_col_offset;
         base_row_ff <= {cur_row_ff[BYTE_W-2:0], 1'b0} + screen_row_offset;
      end
   end

   assign char_sel  = {1'b0, cmd.quarter};
   assign color_sel = {1'b1, cmd.quarter};

   assign rsp_strobe      = cmd.emit;
   assign rsp_screen_col  = base_col_ff + {{(BYTE_W-1){1'b0}}, cmd.quarter[0]};
   assign rsp_screen_row  = base_row_ff + {{(BYTE_W-1){1'b0}}, cmd.quarter[1]};
   assign rsp_char_code   = tile_q_ff[char_sel*BYTE_W +: BYTE_W];
   assign rsp_color_value = tile_q_ff[color_sel*BYTE_W +: BYTE_W];
   assign rsp_cell_last   = cmd.emit && (cmd.quarter == 2'd3);
   assign rsp_map_done    = rsp_cell_last && done_ff;

endmodule

[hw/rtl/metatile_map_expander.sv]
// Top level of the metatile map expander: register file and unit wiring.
//
// Usage: load the map with map cell writes (mode 0) and the metatile table
// with entry writes (mode 1), program width, height and screen offsets over
// the register port, then issue draw steps (mode 2). A command transfers on
// a clock edge with start high and busy low.
// Each draw step expands the cell under the raster cursor into four
// character writes, top-left, top-right, bottom-left, bottom-right, shown
// one per cycle with rsp_strobe high, after the cursor fix, the multiply
// for the cell address and the registered reads of the map store and then
// the metatile table. A new draw step can follow once busy falls after the
// last write. A map cell write is busy in its multiply and write states, an
// entry write in its write state; a draw step on an empty map, and an
// unused mode, leave busy low. Results cannot be held off; the receiver
// takes each in its cycle. Reset puts the cursor at cell (0,0) and clears
// the registers; the map and table hold nothing defined until written.
// Change registers only while idle; the block does not enforce it.
module metatile_map_expander
   import mme_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [BYTE_W-1:0] req_cell_x,
   input  logic [BYTE_W-1:0] req_cell_y,
   input  logic [BYTE_W-1:0] req_tile_index,
   input  logic [BYTE_W-1:0] req_char_top_left,
   input  logic [BYTE_W-1:0] req_char_top_right,
   input  logic [BYTE_W-1:0] req_char_bottom_left,
   input  logic [BYTE_W-1:0] req_char_bottom_right,
   input  logic [BYTE_W-1:0] req_color_top_left,
   input  logic [BYTE_W-1:0] req_color_top_right,
   input  logic [BYTE_W-1:0] req_color_bottom_left,
   input  logic [BYTE_W-1:0] req_color_bottom_right,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_screen_col,
   output logic [BYTE_W-1:0] rsp_screen_row,
   output logic [BYTE_W-1:0] rsp_char_code,
   output logic [BYTE_W-1:0] rsp_color_value,
   output logic              rsp_cell_last,
   output logic              rsp_map_done,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   logic [BYTE_W-1:0] width_ff, height_ff, col_off_ff, row_off_ff;
   logic              csr_wr;
   logic [1:0]        csr_idx;
   logic [BYTE_W-1:0] csr_rd;
   cmd_type           cmd;
   status_type        status;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= '0;
         height_ff  <= '0;
         col_off_ff <= '0;
         row_off_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_MAP_WIDTH:  width_ff   <= pwdata[BYTE_W-1:0];
            CSR_MAP_HEIGHT: height_ff  <= pwdata[BYTE_W-1:0];
            CSR_COL_OFFSET: col_off_ff <= pwdata[BYTE_W-1:0];
            CSR_ROW_OFFSET: row_off_ff <= pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_MAP_WIDTH:  csr_rd = width_ff;
         CSR_MAP_HEIGHT: csr_rd = height_ff;
         CSR_COL_OFFSET: csr_rd = col_off_ff;
         CSR_ROW_OFFSET: csr_rd = row_off_ff;
         default:        csr_rd = '0;
      endcase
   end

   assign prdata = {{(CSR_DW-BYTE_W){1'b0}}, csr_rd};

   mme_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   mme_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .map_width              (width_ff),
      .map_height             (height_ff),
      .screen_col_offset      (col_off_ff),
      .screen_row_offset      (row_off_ff),
      .req_cell_x             (req_cell_x),
      .req_cell_y             (req_cell_y),
      .req_tile_index         (req_tile_index),
      .req_char_top_left      (req_char_top_left),
      .req_char_top_right     (req_char_top_right),
      .req_char_bottom_left   (req_char_bottom_left),
      .req_char_bottom_right  (req_char_bottom_right),
      .req_color_top_left     (req_color_top_left),
      .req_color_top_right    (req_color_top_right),
      .req_color_bottom_left  (req_color_bottom_left),
      .req_color_bottom_right (req_color_bottom_right),
      .rsp_strobe             (rsp_strobe),
      .rsp_screen_col         (rsp_screen_col),
      .rsp_screen_row         (rsp_screen_row),
      .rsp_char_code          (rsp_char_code),
      .rsp_color_value        (rsp_color_value),
      .rsp_cell_last          (rsp_cell_last),
      .rsp_map_done           (rsp_map_done)
   );

endmodule
